[rtl/uart_rb_pkg.sv]
`timescale 1ns / 1ps
package uart_rb_pkg;

	localparam int RX_DEPTH_DEF = 128;
	localparam int TX_DEPTH_DEF = 128;

	localparam logic [7:0] ERR_MASK = 8'h18;

	typedef enum logic [2:0] {
		CMD_RX_CHAR    = 3'd0,
		CMD_TX_DONE    = 3'd1,
		CMD_HOST_WRITE = 3'd2,
		CMD_HOST_READ  = 3'd3,
		CMD_CLEAR_RX   = 3'd4
	} cmd_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} ring_ctrl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} ring_stat_t;

endpackage

[rtl/uart_rb_ring.sv]
`timescale 1ns / 1ps
module uart_rb_ring import uart_rb_pkg::*; #(
	parameter int DEPTH = RX_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ring_ctrl_t ctrl,
	input  logic [7:0] wr_data,
	output logic [7:0] rd_data,
	output ring_stat_t stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0]    mem [DEPTH];
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [AW-1:0] head_nxt;
	logic [AW-1:0] tail_nxt;
	logic [7:0]    rd_data_q;
	logic          do_push;
	logic          do_pop;

	function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign head_nxt   = bump(head_q);
	assign tail_nxt   = bump(tail_q);
	assign stat.empty = (head_q == tail_q);
	assign stat.full  = (head_nxt == tail_q);
	assign do_push    = ctrl.push && !stat.full;
	assign do_pop     = ctrl.pop && !stat.empty;
	assign rd_data    = rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (ctrl.clear) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (do_push) begin
				head_q <= head_nxt;
			end
			if (do_pop) begin
				tail_q <= tail_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[head_q] <= wr_data;
		end
		if (do_pop) begin
			rd_data_q <= mem[tail_q];
		end
	end

endmodule

[rtl/uart_rx_tx_ring_buffers.sv]
`timescale 1ns / 1ps
// The ring entry is read into the ring's read register when a request is accepted,
// and the result is then registered into the output register.
// A new request is not taken while a result is pending or held at the output.
// Reset: both rings empty, transmitter marked busy; ring contents not cleared.
module uart_rx_tx_ring_buffers import uart_rb_pkg::*; #(
	parameter int RX_DEPTH = RX_DEPTH_DEF,
	parameter int TX_DEPTH = TX_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // cmd[2:0], data_byte[10:3], rx_status[18:11], zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // tx_valid[0], tx_byte[8:1], read_byte[16:9],
	                              // rx_available[17], zero
);

	logic        s_fire;
	logic [2:0]  cmd;
	logic [7:0]  data_byte;
	logic [7:0]  rx_status;
	ring_ctrl_t  rx_ctrl;
	ring_ctrl_t  tx_ctrl;
	ring_stat_t  rx_stat;
	ring_stat_t  tx_stat;
	logic [7:0]  rx_rd;
	logic [7:0]  tx_rd;
	logic        tx_busy_q;
	logic        pend_q;
	logic        rx_hit_q;
	logic        tx_hit_q;
	logic        direct_q;
	logic [7:0]  direct_byte_q;
	logic        m_valid_q;
	logic [23:0] m_data_q;
	logic        res_tx_valid;
	logic [7:0]  res_tx_byte;
	logic [7:0]  res_read_byte;

	assign cmd       = s_tdata[2:0];
	assign data_byte = s_tdata[10:3];
	assign rx_status = s_tdata[18:11];
	assign s_tready  = !pend_q && (!m_valid_q || m_tready);
	assign s_fire    = s_tvalid && s_tready;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;

	always_comb begin
		rx_ctrl.push  = s_fire && (cmd == CMD_RX_CHAR) && ((rx_status & ERR_MASK) == 8'h00);
		rx_ctrl.pop   = s_fire && (cmd == CMD_HOST_READ);
		rx_ctrl.clear = s_fire && (cmd == CMD_CLEAR_RX);
		tx_ctrl.push  = s_fire && (cmd == CMD_HOST_WRITE) && tx_busy_q;
		tx_ctrl.pop   = s_fire && (cmd == CMD_TX_DONE);
		tx_ctrl.clear = 1'b0;
	end

	uart_rb_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (rx_ctrl),
		.wr_data (data_byte),
		.rd_data (rx_rd),
		.stat    (rx_stat)
	);

	uart_rb_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (tx_ctrl),
		.wr_data (data_byte),
		.rd_data (tx_rd),
		.stat    (tx_stat)
	);

	always_comb begin
		res_tx_valid  = tx_hit_q || direct_q;
		res_tx_byte   = tx_hit_q ? tx_rd : (direct_q ? direct_byte_q : 8'h00);
		res_read_byte = rx_hit_q ? rx_rd : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_busy_q <= 1'b1;
			pend_q    <= 1'b0;
			rx_hit_q  <= 1'b0;
			tx_hit_q  <= 1'b0;
			direct_q  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			pend_q   <= s_fire;
			rx_hit_q <= rx_ctrl.pop && !rx_stat.empty;
			tx_hit_q <= tx_ctrl.pop && !tx_stat.empty;
			direct_q <= s_fire && (cmd == CMD_HOST_WRITE) && !tx_busy_q;
			if (tx_ctrl.pop && tx_stat.empty) begin
				tx_busy_q <= 1'b0;
			end else if (s_fire && (cmd == CMD_HOST_WRITE)) begin
				tx_busy_q <= 1'b1;
			end
			if (pend_q) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			direct_byte_q <= data_byte;
		end
		if (pend_q) begin
			m_data_q <= {6'h00, !rx_stat.empty, res_read_byte, res_tx_byte, res_tx_valid};
		end
	end

`ifndef SYNTHESIS
	a_pend_shows: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |=> m_tvalid)
		else $error("result not shown after request");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && (cmd == CMD_CLEAR_RX) |=> rx_stat.empty)
		else $error("receive ring not empty after clear");

	a_direct_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && (cmd == CMD_HOST_WRITE) && !tx_busy_q |=> tx_busy_q && tx_stat.empty)
		else $error("direct write did not mark transmitter busy");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !s_tready)
		else $error("request taken while previous result pending");
`endif

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
	import uart_rb_pkg::*;

	localparam logic [2:0] CMD_MAX = 3'd7;
	localparam int HOLD_CYCLES = 400;
	localparam int ITEMS_PER_PHASE = 500;

	typedef struct {
		logic [2:0] cmd;
		logic [7:0] data;
		logic [7:0] status;
	} uart_event_t;

	typedef struct packed {
		logic       rx_avail;
		logic [7:0] rd_byte;
		logic [7:0] tx_byte;
		logic       tx_valid;
	} uart_resp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	uart_event_t uart_events[$];
	uart_resp_t  resp_due[$];
	int          counted_events = 0;
	int          bad_cnt = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic        hold_go = 1'b0;
	int          hold_left = 0;

	logic [7:0] rx_mem[RX_DEPTH_DEF];
	logic [7:0] tx_mem[TX_DEPTH_DEF];
	int         rx_wr = 0;
	int         rx_rd = 0;
	int         tx_wr = 0;
	int         tx_rd = 0;
	logic       tx_busy = 1'b1;

	uart_rx_tx_ring_buffers u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic uart_resp_t uart_event_response(input logic [2:0] cmd,
		input logic [7:0] data, input logic [7:0] status);
		uart_resp_t r;
		int nxt;
		r = '0;
		case (cmd)
			CMD_RX_CHAR: begin
				nxt = (rx_wr + 1) % RX_DEPTH_DEF;
				if ((status & ERR_MASK) == 8'h00 && nxt != rx_rd) begin
					rx_mem[rx_wr] = data;
					rx_wr = nxt;
				end
			end
			CMD_TX_DONE: begin
				if (tx_wr != tx_rd) begin
					r.tx_valid = 1'b1;
					r.tx_byte = tx_mem[tx_rd];
					tx_rd = (tx_rd + 1) % TX_DEPTH_DEF;
				end else begin
					tx_busy = 1'b0;
				end
			end
			CMD_HOST_WRITE: begin
				if (!tx_busy) begin
					r.tx_valid = 1'b1;
					r.tx_byte = data;
					tx_busy = 1'b1;
				end else begin
					nxt = (tx_wr + 1) % TX_DEPTH_DEF;
					if (nxt != tx_rd) begin
						tx_mem[tx_wr] = data;
						tx_wr = nxt;
					end
				end
			end
			CMD_HOST_READ: begin
				if (rx_wr != rx_rd) begin
					r.rd_byte = rx_mem[rx_rd];
					rx_rd = (rx_rd + 1) % RX_DEPTH_DEF;
				end
			end
			CMD_CLEAR_RX: begin
				rx_wr = 0;
				rx_rd = 0;
			end
			default: ;
		endcase
		r.rx_avail = (rx_wr != rx_rd);
		return r;
	endfunction

	task automatic push_event(input logic [2:0] cmd, input logic [7:0] data,
		input logic [7:0] status);
		uart_event_t ev;
		ev.cmd = cmd;
		ev.data = data;
		ev.status = status;
		uart_events.push_back(ev);
		if (cmd <= CMD_CLEAR_RX && !(cmd == CMD_RX_CHAR && (status & ERR_MASK) != 8'h00))
			counted_events++;
	endtask

	function automatic logic [7:0] clean_status();
		return 8'($urandom_range(255)) & ~ERR_MASK;
	endfunction

	task automatic push_burst(input logic [2:0] cmd, input int len);
		logic [7:0] st;
		for (int i = 0; i < len; i++) begin
			st = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : clean_status();
			push_event(cmd, 8'($urandom_range(255)), st);
		end
	endtask

	task automatic add_random_run();
		int kind;
		int len;
		kind = $urandom_range(99);
		len = ($urandom_range(9) == 0) ? $urandom_range(100, 140) : $urandom_range(1, 6);
		if (kind < 25)
			push_burst(CMD_RX_CHAR, len);
		else if (kind < 45)
			push_burst(CMD_HOST_WRITE, len);
		else if (kind < 60)
			push_burst(CMD_TX_DONE, len);
		else if (kind < 78)
			push_burst(CMD_HOST_READ, len);
		else if (kind < 82)
			push_event(CMD_CLEAR_RX, 8'($urandom_range(255)), 8'($urandom_range(255)));
		else
			for (int i = 0; i < len; i++)
				push_event(3'($urandom_range(CMD_MAX)), 8'($urandom_range(255)),
					8'($urandom_range(255)));
	endtask

	task automatic add_directed();
		push_event(CMD_HOST_WRITE, 8'hFF, 8'h00);
		push_event(CMD_TX_DONE, 8'h00, 8'h00);
		push_event(CMD_TX_DONE, 8'h00, 8'h00);
		push_event(CMD_HOST_WRITE, 8'h00, 8'hFF);
		push_event(CMD_HOST_WRITE, 8'hA5, 8'h00);
		push_event(CMD_RX_CHAR, 8'hFF, 8'h00);
		push_event(CMD_RX_CHAR, 8'h00, 8'h08);
		push_event(CMD_RX_CHAR, 8'h11, 8'h10);
		push_event(CMD_RX_CHAR, 8'h22, 8'h18);
		push_event(CMD_RX_CHAR, 8'h80, 8'hE7);
		push_event(CMD_HOST_READ, 8'h00, 8'h00);
		push_event(CMD_HOST_READ, 8'hFF, 8'hFF);
		push_event(CMD_HOST_READ, 8'h00, 8'h00);
		push_event(CMD_RX_CHAR, 8'h5A, 8'h00);
		push_event(CMD_CLEAR_RX, 8'hFF, 8'hFF);
		push_event(CMD_HOST_READ, 8'h00, 8'h00);
		for (int c = CMD_CLEAR_RX + 1; c <= CMD_MAX; c++)
			push_event(3'(c), 8'hFF, 8'hFF);
		push_event(CMD_TX_DONE, 8'h00, 8'h00);
		push_event(CMD_TX_DONE, 8'h00, 8'h00);
		push_event(CMD_HOST_WRITE, 8'h3C, 8'h00);
	endtask

	// fill both rings past capacity, then drain them past empty
	task automatic add_ring_fill();
		for (int i = 0; i < RX_DEPTH_DEF + 7; i++)
			push_event(CMD_RX_CHAR, 8'($urandom_range(255)), clean_status());
		push_burst(CMD_HOST_READ, RX_DEPTH_DEF + 7);
		push_burst(CMD_HOST_WRITE, TX_DEPTH_DEF + 7);
		push_burst(CMD_TX_DONE, TX_DEPTH_DEF + 7);
	endtask

	always @(posedge clk or negedge arst_n) begin : drv
		uart_event_t ev;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (uart_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				ev = uart_events.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {5'b0, ev.status, ev.data, ev.cmd};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_go)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : mon
		uart_resp_t got;
		uart_resp_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				resp_due.push_back(uart_event_response(s_tdata[2:0], s_tdata[10:3],
					s_tdata[18:11]));
			if (m_tvalid && m_tready) begin
				got = m_tdata[17:0];
				if (resp_due.size() == 0) begin
					bad_cnt++;
					if (bad_cnt <= 10)
						$display("unexpected response %h at %0t", got, $realtime);
				end else begin
					want = resp_due.pop_front();
					if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
						got.rd_byte !== want.rd_byte || got.rx_avail !== want.rx_avail) begin
						bad_cnt++;
						if (bad_cnt <= 10) begin
							$write("mismatch at %0t: tx_valid %b/%b tx_byte %h/%h ",
								$realtime, want.tx_valid, got.tx_valid, want.tx_byte,
								got.tx_byte);
							$display("read_byte %h/%h rx_available %b/%b (exp/got)",
								want.rd_byte, got.rd_byte, want.rx_avail, got.rx_avail);
						end
					end
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < 4; phase++) begin
			@(posedge clk);
			case (phase)
				0: begin send_idle_pct <= 0; recv_stall_pct <= 0; end
				1: begin send_idle_pct <= 49; recv_stall_pct <= 0; end
				2: begin send_idle_pct <= 0; recv_stall_pct <= 49; end
				default: begin send_idle_pct <= 17; recv_stall_pct <= 17; end
			endcase
			if (phase == 0) begin
				add_directed();
				add_ring_fill();
			end
			while (counted_events < (phase + 1) * ITEMS_PER_PHASE)
				add_random_run();
			if (phase == 0) begin
				@(posedge clk);
				hold_go <= 1'b1;
				@(posedge clk);
				hold_go <= 1'b0;
			end
			while (uart_events.size() != 0 || s_tvalid || resp_due.size() != 0)
				@(negedge clk);
		end
		repeat (10) @(posedge clk);
		if (resp_due.size() != 0) begin
			bad_cnt++;
			$display("%0d responses never arrived", resp_due.size());
		end
		if (bad_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
